// ----- src/rlbd_pkg.sv -----
// Shared types for the run-length byte decoder: command queue entry, result
// record, state encodings and status codes. No dependencies.
`timescale 1ns / 1ps

package rlbd_pkg;

    localparam int CNT_W      = 17;
    localparam int FIFO_DEPTH = 2;   // power of two: pointers wrap freely
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [1:0] ST_RUNNING = 2'd0;
    localparam logic [1:0] ST_OK      = 2'd1;
    localparam logic [1:0] ST_NO_TERM = 2'd2;

    typedef enum logic [1:0] {
        PH_CTRL,
        PH_REPEAT,
        PH_LITERAL
    } front_phase_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

    // One classified source byte, queued for the emitter.
    typedef struct packed {
        logic [7:0]       data;      // byte to repeat or copy
        logic [6:0]       len;       // bytes to emit: run length, 1 or 0
        logic             close;     // this byte closes the stream
        logic             term;      // close came from a terminator byte
        logic [CNT_W-1:0] consumed;  // source count including this byte
    } cmd_t;

    typedef struct packed {
        logic [7:0]       data_first;
        logic [7:0]       data_second;
        logic [1:0]       byte_count;
        logic             run_last;
        logic             stream_done;
        logic [1:0]       status;
        logic [CNT_W-1:0] bytes_written;
        logic [CNT_W-1:0] bytes_consumed;
    } res_t;

endpackage

// ----- src/run_length_byte_decoder_core.sv -----
// Top level of the signed-count run-length byte decoder: capacity register,
// front end, command queue and emitter. Uses rlbd_pkg and the rlbd_* modules.
//
// Usage:
//   Source beats enter on s_tvalid/s_tready; s_tdata[7:0] is the encoded
//   byte and s_tlast flags the last byte of a source stream. A control byte
//   is a signed count: zero terminates, +n repeats the next byte n times,
//   -n copies the next n bytes as literals.
//   Result beats leave on m_tvalid/m_tready, each carrying up to two decoded
//   bytes plus the running written and consumed counts. m_tlast marks the
//   last result caused by one source byte; m_tuser flags the closing result
//   and its status.
//   cfg_wr_en/cfg_wr_data load the output capacity; write it only while idle.
//   Flow: a source beat is written into the queue, popped into the emitter's
//   command registers, and its first result is then registered at the output.
//   A repeat run goes out up to two bytes per result, a literal byte as one;
//   the emitter finishes one command before popping the next and so sets the
//   throughput, while the two-entry queue lets source beats continue during a run.
//   Reset: synchronous, active low; clears the stream state, empties the
//   queue, drops any pending result and sets the capacity to 65536.
//   Stall: while m_tready is low the current result holds, the emitter waits,
//   and once the queue fills s_tready drops.
`timescale 1ns / 1ps

module run_length_byte_decoder_core
    import rlbd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data,   // out_capacity
    // source channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] src_byte
    input  logic        s_tlast,       // src_last
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,       // [7:0] data_first, [15:8] data_second,
                                       // [17:16] byte_count, [34:18] bytes_written,
                                       // [51:35] bytes_consumed, [55:52] zero
    output logic        m_tlast,       // run_last
    output logic [2:0]  m_tuser        // [0] stream_done, [2:1] status
);

    localparam logic [CNT_W-1:0] CAP_LIMIT = 17'h10000;

    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] cap_eff;

    logic q_push, q_pop, q_full, q_empty;
    cmd_t q_cmd, q_head;
    res_t res;

    // Hold the capacity; clamp to the supported output limit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_LIMIT;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    assign cap_eff = (cap_reg > CAP_LIMIT) ? CAP_LIMIT : cap_reg;

    rlbd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    rlbd_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head_cmd (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    rlbd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cap       (cap_eff),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // Pack the result record onto the stream bus.
    assign m_tdata = {4'd0, res.bytes_consumed, res.bytes_written, res.byte_count,
                      res.data_second, res.data_first};
    assign m_tlast = res.run_last;
    assign m_tuser = {res.status, res.stream_done};

endmodule

// ----- src/rlbd_front.sv -----
// Front end: accepts source beats, tracks control/run phase and source count,
// and queues one command per byte that may yield results. Uses rlbd_pkg.
`timescale 1ns / 1ps

module rlbd_front
    import rlbd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd
);

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    front_phase_t     phase_reg, phase_next;
    logic [7:0]       remaining_reg, remaining_next;
    logic [CNT_W-1:0] consumed_reg, consumed_next;
    logic             finished_reg, finished_next;

    logic             accept;
    logic [CNT_W-1:0] consumed_inc;
    logic             close;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign consumed_inc = (consumed_reg == CNT_MAX) ? consumed_reg
                                                    : consumed_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_CTRL;
            remaining_reg <= '0;
            consumed_reg  <= '0;
            finished_reg  <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            consumed_reg  <= consumed_next;
            finished_reg  <= finished_next;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        consumed_next  = consumed_reg;
        finished_next  = finished_reg;
        q_push         = 1'b0;
        close          = 1'b0;
        q_cmd.data     = in_byte;
        q_cmd.len      = '0;
        q_cmd.close    = 1'b0;
        q_cmd.term     = 1'b0;
        q_cmd.consumed = consumed_inc;

        if (accept) begin
            if (finished_reg) begin
                // drop trailing bytes; the flagged last one rearms the stream
                if (in_last) begin
                    phase_next     = PH_CTRL;
                    remaining_next = '0;
                    consumed_next  = '0;
                    finished_next  = 1'b0;
                end
            end else begin
                consumed_next = consumed_inc;
                unique case (phase_reg)
                    PH_REPEAT: begin
                        q_push         = 1'b1;
                        q_cmd.len      = remaining_reg[6:0];
                        phase_next     = PH_CTRL;
                        remaining_next = '0;
                    end
                    PH_LITERAL: begin
                        q_push         = 1'b1;
                        q_cmd.len      = 7'd1;
                        remaining_next = remaining_reg - 1'b1;
                        if (remaining_reg == 8'd1) begin
                            phase_next = PH_CTRL;
                        end
                    end
                    default: begin
                        if (in_byte == 8'd0) begin
                            q_cmd.term = 1'b1;
                            q_push     = 1'b1;
                        end else if (!in_byte[7]) begin
                            phase_next     = PH_REPEAT;
                            remaining_next = in_byte;
                        end else begin
                            phase_next     = PH_LITERAL;
                            remaining_next = 8'd0 - in_byte;
                        end
                        if (in_last) begin
                            q_push = 1'b1;
                        end
                    end
                endcase

                close       = q_cmd.term || in_last;
                q_cmd.close = close;
                if (close) begin
                    phase_next     = PH_CTRL;
                    remaining_next = '0;
                    consumed_next  = '0;
                    finished_next  = !in_last;
                end
            end
        end
    end

endmodule

// ----- src/rlbd_cmd_fifo.sv -----
// Short command queue between front end and emitter, held in flip-flops.
// Uses rlbd_pkg for the entry type and depth.
`timescale 1ns / 1ps

module rlbd_cmd_fifo
    import rlbd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head_cmd,
    output logic full,
    output logic empty
);

    cmd_t               entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;

    assign full     = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + (push ? 1'b1 : 1'b0);
        rd_ptr_next = rd_ptr_reg + (pop ? 1'b1 : 1'b0);
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- src/rlbd_back.sv -----
// Emitter: pops commands, writes decoded bytes up to two per result against the
// capacity limit, appends closing status, drives the output register. Uses rlbd_pkg.
`timescale 1ns / 1ps

module rlbd_back
    import rlbd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CNT_W-1:0] cap,
    input  logic             q_empty,
    input  cmd_t             q_head,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output res_t             out_res
);

    back_state_t      state_reg, state_next;
    logic [CNT_W-1:0] written_reg, written_next;
    logic [6:0]       left_reg, left_next;
    logic [7:0]       data_reg, data_next;
    logic             close_reg, close_next;
    logic [1:0]       status_reg, status_next;
    logic [CNT_W-1:0] consumed_reg, consumed_next;
    logic             out_valid_reg, out_valid_next;
    res_t             out_res_reg, out_res_next;

    logic             slot_free;
    logic             can_write;
    logic             two;
    logic [CNT_W:0]   written_plus1;
    logic [CNT_W-1:0] written_step;
    logic [6:0]       left_step;
    logic             final_beat;

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign slot_free = !out_valid_reg || out_ready;

    assign written_plus1 = {1'b0, written_reg} + 1'b1;
    assign can_write     = (left_reg != '0) && (written_reg < cap);
    assign two           = (left_reg >= 7'd2) && (written_plus1 < {1'b0, cap});
    assign written_step  = written_reg + (two ? CNT_W'(2) : CNT_W'(1));
    assign left_step     = left_reg - (two ? 7'd2 : 7'd1);
    assign final_beat    = !((left_step != '0) && (written_step < cap));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            written_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            written_reg   <= written_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        left_reg     <= left_next;
        data_reg     <= data_next;
        close_reg    <= close_next;
        status_reg   <= status_next;
        consumed_reg <= consumed_next;
        out_res_reg  <= out_res_next;
    end

    always_comb begin
        state_next     = state_reg;
        written_next   = written_reg;
        left_next      = left_reg;
        data_next      = data_reg;
        close_next     = close_reg;
        status_next    = status_reg;
        consumed_next  = consumed_reg;
        out_res_next   = out_res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        q_pop          = 1'b0;

        unique case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    q_pop         = 1'b1;
                    left_next     = q_head.len;
                    data_next     = q_head.data;
                    close_next    = q_head.close;
                    consumed_next = q_head.consumed;
                    // a terminator with nothing allowed out still reports failure
                    status_next   = (q_head.term && cap != '0) ? ST_OK : ST_NO_TERM;
                    state_next    = BK_RUN;
                end
            end
            BK_RUN: begin
                if (can_write) begin
                    if (slot_free) begin
                        out_valid_next              = 1'b1;
                        out_res_next.data_first     = data_reg;
                        out_res_next.data_second    = two ? data_reg : 8'd0;
                        out_res_next.byte_count     = two ? 2'd2 : 2'd1;
                        out_res_next.run_last       = final_beat;
                        out_res_next.stream_done    = final_beat && close_reg;
                        out_res_next.status         = (final_beat && close_reg) ?
                                                      status_reg : ST_RUNNING;
                        out_res_next.bytes_written  = written_step;
                        out_res_next.bytes_consumed = consumed_reg;
                        written_next                = written_step;
                        left_next                   = left_step;
                        if (final_beat) begin
                            state_next = BK_IDLE;
                            if (close_reg) begin
                                written_next = '0;
                            end
                        end
                    end
                end else if (close_reg) begin
                    // close with nothing to write (no bytes left or capacity reached): emit an empty closing result
                    if (slot_free) begin
                        out_valid_next              = 1'b1;
                        out_res_next.data_first     = 8'd0;
                        out_res_next.data_second    = 8'd0;
                        out_res_next.byte_count     = 2'd0;
                        out_res_next.run_last       = 1'b1;
                        out_res_next.stream_done    = 1'b1;
                        out_res_next.status         = status_reg;
                        out_res_next.bytes_written  = written_reg;
                        out_res_next.bytes_consumed = consumed_reg;
                        written_next                = '0;
                        state_next                  = BK_IDLE;
                    end
                end else begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

endmodule

// ----- src/rlbd_checker.sv -----
// Port-level checks for the run-length byte decoder, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module rlbd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tlast,
    input logic [2:0]  m_tuser
);

    // a closing result is always the last one of its source byte
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("stream_done without run_last");

    // status stays zero on results that do not close the stream
    a_status_only_on_close: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tuser[2:1] == 2'd0)
        else $error("status set on a running result");

    // byte count is 0..2 and the second byte is zero unless it is carried
    a_second_byte_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[17:16] != 2'd2 |-> m_tdata[15:8] == 8'd0 &&
        m_tdata[17:16] != 2'd3)
        else $error("bad byte count or stray second byte");

    // a stalled result holds
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

endmodule

bind run_length_byte_decoder_core rlbd_checker u_rlbd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
